FILE: rtl/kmcm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix to MIDI notes: shared package
// Types, constants and the key position ROM used by the front end, the
// request queue and the event generator.
// ----------------------------------------------------------------------------
package kmcm_pkg;

   localparam int KEY_COUNT = 32;
   localparam int KEY_IDX_W = $clog2(KEY_COUNT);

   // MIDI constants.
   localparam logic [6:0] NOTE_OFFSET_RESET = 7'd36;
   localparam logic [6:0] NOTE_OFFSET_MAX   = 7'd96;
   localparam logic [6:0] VELOCITY_ON       = 7'd127;
   localparam logic [6:0] VELOCITY_OFF      = 7'd0;

   // Queue between the front end and the event generator.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // One classified scan: the changed keys and the new line states.
   typedef struct packed {
      logic [KEY_COUNT-1:0] changed;
      logic [KEY_COUNT-1:0] lines;
   } kmcm_scan_type;

   // Key position of each matrix bit.
   function automatic logic [4:0] key_position(input logic [KEY_IDX_W-1:0] bit_idx);
      logic [4:0] pos;
      unique case (bit_idx)
         5'd0:  pos = 5'd23;
         5'd1:  pos = 5'd21;
         5'd2:  pos = 5'd19;
         5'd3:  pos = 5'd17;
         5'd4:  pos = 5'd15;
         5'd5:  pos = 5'd13;
         5'd6:  pos = 5'd25;
         5'd7:  pos = 5'd26;
         5'd8:  pos = 5'd24;
         5'd9:  pos = 5'd22;
         5'd10: pos = 5'd20;
         5'd11: pos = 5'd18;
         5'd12: pos = 5'd16;
         5'd13: pos = 5'd14;
         5'd14: pos = 5'd12;
         5'd15: pos = 5'd27;
         5'd16: pos = 5'd0;
         5'd17: pos = 5'd2;
         5'd18: pos = 5'd4;
         5'd19: pos = 5'd6;
         5'd20: pos = 5'd8;
         5'd21: pos = 5'd10;
         5'd22: pos = 5'd28;
         5'd23: pos = 5'd29;
         5'd24: pos = 5'd1;
         5'd25: pos = 5'd3;
         5'd26: pos = 5'd5;
         5'd27: pos = 5'd7;
         5'd28: pos = 5'd9;
         5'd29: pos = 5'd11;
         5'd30: pos = 5'd30;
         5'd31: pos = 5'd31;
         default: pos = 5'd0;
      endcase
      return pos;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/kmcm_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix to MIDI notes: front end
// Accepts key snapshots, compares them with the previous snapshot and
// forwards only scans that changed at least one key.
// ----------------------------------------------------------------------------
module kmcm_front
   import kmcm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic [KEY_COUNT-1:0] req_key_lines,
   output logic                      req_full,
   output logic                      q_push,
   output kmcm_scan_type             q_entry,
   input  wire logic                 q_full
);

   logic [KEY_COUNT-1:0] prev_keys_ff;
   logic [KEY_COUNT-1:0] prev_keys_in;
   logic                 accept;

   // A request is taken whenever the queue has room.
   assign req_full = q_full;
   assign accept   = req_push && !q_full;

   // Classify: only a scan with changed keys goes on to the queue.
   always_comb begin
      q_entry.changed = req_key_lines ^ prev_keys_ff;
      q_entry.lines   = req_key_lines;
      q_push          = accept && (q_entry.changed != '0);
      prev_keys_in    = accept ? req_key_lines : prev_keys_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_keys_ff <= '0;
      end else begin
         prev_keys_ff <= prev_keys_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/kmcm_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix to MIDI notes: scan queue
// A short first-in first-out queue that decouples the front end from the
// event generator.
// ----------------------------------------------------------------------------
module kmcm_queue
   import kmcm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire kmcm_scan_type push_entry,
   output logic               full,
   input  wire logic          pop,
   output kmcm_scan_type      pop_entry,
   output logic               empty
);

   kmcm_scan_type             slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]    wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff;
   logic [QUEUE_CNT_W-1:0]    count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign pop_entry = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && !empty;

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/kmcm_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key matrix to MIDI notes: event generator
// Takes one changed scan at a time and emits one note event per changed
// key, lowest bit first, into a registered output stage.
// ----------------------------------------------------------------------------
module kmcm_back
   import kmcm_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [6:0]    note_offset,
   input  wire kmcm_scan_type q_entry,
   input  wire logic          q_empty,
   output logic               q_pop,
   output logic               rsp_empty,
   input  wire logic          rsp_pop,
   output logic               rsp_note_on,
   output logic [6:0]         rsp_note_number,
   output logic [6:0]         rsp_velocity,
   output logic               rsp_last
);

   logic                    busy_ff;
   logic                    busy_in;
   logic [KEY_COUNT-1:0]    changed_ff;
   logic [KEY_COUNT-1:0]    changed_in;
   logic [KEY_COUNT-1:0]    lines_ff;
   logic [KEY_COUNT-1:0]    lines_in;
   logic                    out_valid_ff;
   logic                    out_valid_in;
   logic                    note_on_ff;
   logic [6:0]              note_number_ff;
   logic                    last_ff;
   logic                    out_free;
   logic                    emit;
   logic [KEY_COUNT-1:0]    low_bit;
   logic [KEY_COUNT-1:0]    remaining;
   logic [KEY_IDX_W-1:0]    low_idx;
   logic [6:0]              offset_used;
   logic                    pressed;

   assign out_free = !out_valid_ff || rsp_pop;
   assign q_pop    = !busy_ff && !q_empty;
   assign emit     = busy_ff && out_free;

   // Isolate the lowest changed key and encode its bit index.
   always_comb begin
      low_bit   = changed_ff & (~changed_ff + 1'b1);
      remaining = changed_ff & ~low_bit;
      low_idx   = '0;
      for (int i = 0; i < KEY_COUNT; i++) begin
         if (low_bit[i]) begin
            low_idx = low_idx | KEY_IDX_W'(i);
         end
      end
      pressed     = ((lines_ff & low_bit) == '0);
      offset_used = (note_offset > NOTE_OFFSET_MAX) ? NOTE_OFFSET_MAX : note_offset;
   end

   // Scan walk control and output stage valid.
   always_comb begin
      busy_in      = busy_ff;
      changed_in   = changed_ff;
      lines_in     = lines_ff;
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         busy_in    = 1'b1;
         changed_in = q_entry.changed;
         lines_in   = q_entry.lines;
      end else if (emit) begin
         changed_in = remaining;
         busy_in    = (remaining != '0);
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      changed_ff <= changed_in;
      lines_ff   <= lines_in;
      if (emit) begin
         note_on_ff     <= pressed;
         note_number_ff <= offset_used + 7'(key_position(low_idx));
         last_ff        <= (remaining == '0);
      end
   end

   assign rsp_empty       = !out_valid_ff;
   assign rsp_note_on     = note_on_ff;
   assign rsp_note_number = note_number_ff;
   assign rsp_velocity    = note_on_ff ? VELOCITY_ON : VELOCITY_OFF;
   assign rsp_last        = last_ff;

endmodule
`default_nettype wire

FILE: rtl/key_matrix_change_to_midi_notes_core.sv
`timescale 1ns / 1ps
`default_nettype none
// The first note event of a request passes through the queue, the scan load in the
// event generator and its registered output stage. The event generator loads each
// changed scan, then emits one note event per changed key; unchanged scans are dropped.
// A two-entry queue lets new requests be accepted while events are still being emitted.
// Reset clears the previous snapshot to zero and sets the note offset to 36.
// ----------------------------------------------------------------------------
// Key matrix to MIDI notes: top level
// Turns key matrix snapshots into MIDI note-on and note-off events.
// ----------------------------------------------------------------------------
module key_matrix_change_to_midi_notes_core
   import kmcm_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_push,
   input  wire logic [KEY_COUNT-1:0] req_key_lines,
   output logic                      req_full,
   output logic                      rsp_empty,
   input  wire logic                 rsp_pop,
   output logic                      rsp_note_on,
   output logic [6:0]                rsp_note_number,
   output logic [6:0]                rsp_velocity,
   output logic                      rsp_last,
   input  wire logic                 csr_wr_en,
   input  wire logic [6:0]           csr_wr_data
);

   logic [6:0]     note_offset_ff;
   logic [6:0]     note_offset_in;
   logic           q_push;
   logic           q_full;
   logic           q_pop;
   logic           q_empty;
   kmcm_scan_type  q_push_entry;
   kmcm_scan_type  q_pop_entry;

   // Note offset register; the written bits are kept and clamped at use.
   assign note_offset_in = csr_wr_en ? csr_wr_data : note_offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         note_offset_ff <= NOTE_OFFSET_RESET;
      end else begin
         note_offset_ff <= note_offset_in;
      end
   end

   kmcm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_key_lines (req_key_lines),
      .req_full      (req_full),
      .q_push        (q_push),
      .q_entry       (q_push_entry),
      .q_full        (q_full)
   );

   kmcm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .pop_entry  (q_pop_entry),
      .empty      (q_empty)
   );

   kmcm_back u_back (
      .clock           (clock),
      .reset           (reset),
      .note_offset     (note_offset_ff),
      .q_entry         (q_pop_entry),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_empty       (rsp_empty),
      .rsp_pop         (rsp_pop),
      .rsp_note_on     (rsp_note_on),
      .rsp_note_number (rsp_note_number),
      .rsp_velocity    (rsp_velocity),
      .rsp_last        (rsp_last)
   );

endmodule
`default_nettype wire
